>>> sv/gradient_matrix_combine_macros.svh
// Assertion macros shared by the gradient matrix combine modules.
`ifndef GRADIENT_MATRIX_COMBINE_MACROS_SVH
`define GRADIENT_MATRIX_COMBINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GMC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GMC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GMC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/gmc_pkg.sv
// Shared types, constants and helpers of the gradient matrix combine block.
package gmc_pkg;
  localparam int MaxDim = 8;
  localparam int Depth = MaxDim * MaxDim;
  localparam int AddrW = $clog2(Depth);
  localparam int DimW = $clog2(MaxDim + 1);
  localparam int CntW = AddrW + 1;

  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegLowerRows = 3'd1;
  localparam logic [2:0] RegLowerCols = 3'd2;
  localparam logic [2:0] RegUpperRows = 3'd3;
  localparam logic [2:0] RegUpperCols = 3'd4;
  localparam logic [2:0] RegTargetRows = 3'd5;
  localparam logic [2:0] RegTargetCols = 3'd6;

  typedef enum logic [2:0] {
    RULE_NONE = 3'd0, RULE_EW_T = 3'd1, RULE_EW = 3'd2, RULE_LU = 3'd3,
    RULE_UL = 3'd4, RULE_ULT = 3'd5, RULE_LTU = 3'd6
  } rule_t;

  // Read port request from the sequencer to the stores.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] laddr;
    logic [AddrW-1:0] uaddr;
  } rd_req_t;

  // Control that travels alongside read data into the datapath.
  typedef struct packed {
    logic valid;
    logic first;
    logic last_k;
    logic last_elem;
    logic matched;
  } dp_ctl_t;

  function automatic logic [DimW-1:0] dim_clamp(input logic [3:0] d);
    logic [DimW-1:0] r;
    if (d == 4'd0) r = DimW'(1);
    else if (32'(d) > MaxDim) r = DimW'(MaxDim);
    else r = DimW'(d);
    return r;
  endfunction
endpackage

>>> sv/gmc_store.sv
// Lower and upper element memories with one write and one registered read port each.
module gmc_store (
  input  logic                      clk,
  input  logic                      lwe,
  input  logic                      uwe,
  input  logic [gmc_pkg::AddrW-1:0] waddr,
  input  logic [31:0]               wdata,
  input  gmc_pkg::rd_req_t          req,
  output logic [31:0]               ldata,
  output logic [31:0]               udata
);
  logic [31:0] lmem [gmc_pkg::Depth];
  logic [31:0] umem [gmc_pkg::Depth];

  always_ff @(posedge clk) begin
    if (lwe) lmem[waddr] <= wdata;
    if (uwe) umem[waddr] <= wdata;
    if (req.en) begin
      ldata <= lmem[req.laddr];
      udata <= umem[req.uaddr];
    end
  end
endmodule

>>> sv/gmc_mac.sv
// Rounded Q16.16 multiply and saturating accumulate, two stages deep.
module gmc_mac (
  input  logic             clk,
  input  logic             rst,
  input  gmc_pkg::dp_ctl_t ctl,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output logic             out_valid,
  output logic [31:0]      out_value,
  output logic             out_last,
  output logic             out_matched
);
  logic signed [63:0] prod;
  gmc_pkg::dp_ctl_t   ctl_q;
  logic signed [51:0] rounded;
  logic signed [51:0] acc;
  logic signed [51:0] acc_next;

  always_ff @(posedge clk) begin
    prod <= $signed(a) * $signed(b);
    if (rst) ctl_q <= '0;
    else ctl_q <= ctl;
  end

  // A rounded product needs 48 bits; a sum of eight of them needs 51.
  assign rounded = 52'((prod + 64'sd32768) >>> 16);
  assign acc_next = (ctl_q.first ? 52'sd0 : acc) + rounded;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl_q.valid && ctl_q.last_k;
    end
    if (ctl_q.valid) acc <= acc_next;
    if (ctl_q.valid && ctl_q.last_k) begin
      if (!ctl_q.matched) out_value <= 32'd0;
      else if (acc_next > 52'sh7FFFFFFF) out_value <= 32'h7FFFFFFF;
      else if (acc_next < -52'sh80000000) out_value <= 32'h80000000;
      else out_value <= acc_next[31:0];
      out_last <= ctl_q.last_elem;
      out_matched <= ctl_q.matched;
    end
  end
endmodule

>>> sv/gradient_matrix_combine.sv
// Top level of the gradient matrix combine block: load, sequence, output.
// Usage: set the seven registers over the write port while idle, then send
// lower elements (kind 0) and upper elements (kind 1) in column-major order
// on the in channel, one per cycle. The upper element that completes the
// upper matrix starts computing; no item is accepted until every result has
// been taken from the out channel; ready returns when the drain state, with
// nothing in flight and the queue empty, goes back to the load state.
// Each result element takes K memory reads (K = inner length, 1 in
// elementwise mode or for unmatched shapes), one at a time through the
// single read port of each store feeding one multiplier. At most two
// results may be outstanding. Each result passes from the store reads
// through the multiply and accumulate stages into the output queue.
// Results pass through a two-entry queue; when the receiver stalls, the
// read sequencer pauses and nothing is lost.
// Reset returns registers to their reset values and both load counts to
// zero; store contents are undefined until written.
module gradient_matrix_combine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        valid,
  output logic        ready,
  input  logic        kind,
  input  logic [31:0] element_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_value,
  output logic        last_element,
  output logic        shape_matched
);
  `include "gradient_matrix_combine_macros.svh"
  localparam int AW = gmc_pkg::AddrW;
  localparam int DW = gmc_pkg::DimW;

  typedef enum logic [2:0] {
    S_LOAD = 3'b001, S_RUN = 3'b010, S_DRAIN = 3'b100
  } state_t;

  state_t state;
  logic mode;
  logic [3:0] lrows, lcols, urows, ucols, trows, tcols;
  logic [gmc_pkg::CntW-1:0] lcnt, ucnt;
  logic [DW-1:0] lr, lc, ur, uc, tr, tc;
  logic [DW-1:0] rows, cols, klen;
  gmc_pkg::rule_t rule;
  logic [DW-1:0] ii, jj, kk;
  logic [DW-1:0] li, lj, ui, uj;
  gmc_pkg::rd_req_t req;
  gmc_pkg::dp_ctl_t ctl, ctl_d;
  logic [31:0] ldata, udata;
  logic mv;
  logic [31:0] mval;
  logic mlast, mmatch;
  logic [2:0] inflight;
  logic [1:0] qcnt;
  logic [33:0] q [2];
  logic qrd, qwr;
  logic acc_in;
  logic lwe, uwe;
  logic [AW-1:0] waddr;
  logic trigger;
  logic step_last;
  logic done_issue;
  logic matched;

  always_comb begin
    lr = gmc_pkg::dim_clamp(lrows);
    lc = gmc_pkg::dim_clamp(lcols);
    ur = gmc_pkg::dim_clamp(urows);
    uc = gmc_pkg::dim_clamp(ucols);
    tr = gmc_pkg::dim_clamp(trows);
    tc = gmc_pkg::dim_clamp(tcols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      lrows <= 4'd1; lcols <= 4'd1; urows <= 4'd1;
      ucols <= 4'd1; trows <= 4'd1; tcols <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gmc_pkg::RegMode: mode <= cfg_data[0];
        gmc_pkg::RegLowerRows: lrows <= cfg_data;
        gmc_pkg::RegLowerCols: lcols <= cfg_data;
        gmc_pkg::RegUpperRows: urows <= cfg_data;
        gmc_pkg::RegUpperCols: ucols <= cfg_data;
        gmc_pkg::RegTargetRows: trows <= cfg_data;
        gmc_pkg::RegTargetCols: tcols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shape rule selection, in priority order.
  always_comb begin
    rows = lr; cols = lc; klen = DW'(1); rule = gmc_pkg::RULE_NONE;
    if (!mode) begin
      if (lr == uc && lc == ur) rule = gmc_pkg::RULE_EW_T;
      else if (lr == ur && lc == uc) rule = gmc_pkg::RULE_EW;
    end else begin
      rows = tr; cols = tc;
      if (tr == lr && tc == uc && lc == ur) begin
        rule = gmc_pkg::RULE_LU; klen = lc;
      end else if (tr == ur && tc == lc && uc == lr) begin
        rule = gmc_pkg::RULE_UL; klen = uc;
      end else if (tr == ur && tc == lr && uc == lc) begin
        rule = gmc_pkg::RULE_ULT; klen = uc;
      end else if (tr == lc && tc == uc && lr == ur) begin
        rule = gmc_pkg::RULE_LTU; klen = lr;
      end
    end
  end
  assign matched = (rule != gmc_pkg::RULE_NONE);

  // Loader.
  assign ready = (state == S_LOAD);
  assign acc_in = valid && ready;
  assign lwe = acc_in && !kind && (32'(lcnt) < 32'(lr) * 32'(lc));
  assign uwe = acc_in && kind && (32'(ucnt) < 32'(ur) * 32'(uc));
  assign waddr = kind ? ucnt[AW-1:0] : lcnt[AW-1:0];
  assign trigger = acc_in && kind && (32'(ucnt) + 32'(uwe) >= 32'(ur) * 32'(uc));

  // Operand coordinates (row, column) in each store for index (ii, jj, kk).
  always_comb begin
    li = ii; lj = jj; ui = ii; uj = jj;
    case (rule)
      gmc_pkg::RULE_EW_T: begin ui = jj; uj = ii; end
      gmc_pkg::RULE_LU: begin lj = kk; ui = kk; end
      gmc_pkg::RULE_UL: begin uj = kk; li = kk; end
      gmc_pkg::RULE_ULT: begin uj = kk; li = jj; lj = kk; end
      gmc_pkg::RULE_LTU: begin li = kk; lj = ii; ui = kk; end
      default: ;
    endcase
  end

  // Issue only while the queue has room for everything in flight.
  assign req.en = (state == S_RUN) && (32'(qcnt) + 32'(inflight) < 2);
  assign req.laddr = AW'(32'(lj) * 32'(lr) + 32'(li));
  assign req.uaddr = AW'(32'(uj) * 32'(ur) + 32'(ui));
  assign step_last = (32'(kk) + 1 == 32'(klen));
  assign done_issue = step_last && (32'(ii) + 1 == 32'(rows)) &&
                      (32'(jj) + 1 == 32'(cols));

  always_comb begin
    ctl.valid = req.en;
    ctl.first = (kk == '0);
    ctl.last_k = step_last;
    ctl.last_elem = done_issue;
    ctl.matched = matched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      lcnt <= '0; ucnt <= '0;
      ii <= '0; jj <= '0; kk <= '0;
      ctl_d <= '0;
    end else begin
      ctl_d <= ctl;
      unique case (state)
        S_LOAD: begin
          if (lwe) lcnt <= lcnt + 1'b1;
          if (uwe) ucnt <= ucnt + 1'b1;
          if (trigger) begin
            state <= S_RUN;
            ii <= '0; jj <= '0; kk <= '0;
          end
        end
        S_RUN: begin
          if (req.en) begin
            if (!step_last) kk <= kk + 1'b1;
            else begin
              kk <= '0;
              if (32'(ii) + 1 < 32'(rows)) ii <= ii + 1'b1;
              else begin
                ii <= '0;
                jj <= jj + 1'b1;
              end
            end
            if (done_issue) state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (inflight == '0 && qcnt == '0) begin
            state <= S_LOAD;
            lcnt <= '0; ucnt <= '0;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Counts issued results not yet in the queue (read, multiply, accumulate).
  logic iss_res;
  assign iss_res = req.en && step_last;
  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else inflight <= inflight + 3'(iss_res) - 3'(mv);
  end

  gmc_store u_store (
    .clk(clk), .lwe(lwe), .uwe(uwe), .waddr(waddr), .wdata(element_value),
    .req(req), .ldata(ldata), .udata(udata)
  );

  gmc_mac u_mac (
    .clk(clk), .rst(rst), .ctl(ctl_d), .a(ldata), .b(udata),
    .out_valid(mv), .out_value(mval), .out_last(mlast), .out_matched(mmatch)
  );

  // Two-entry output queue.
  assign qwr = mv;
  assign qrd = out_valid && out_ready;
  assign out_valid = (qcnt != '0);
  assign result_value = q[0][31:0];
  assign last_element = q[0][32];
  assign shape_matched = q[0][33];

  always_ff @(posedge clk) begin
    if (rst) qcnt <= '0;
    else qcnt <= qcnt + 2'(qwr) - 2'(qrd);
    if (qrd) begin
      if (qwr && qcnt == 2'd1) q[0] <= {mmatch, mlast, mval};
      else begin
        q[0] <= q[1];
        if (qwr) q[1] <= {mmatch, mlast, mval};
      end
    end else if (qwr) begin
      if (qcnt == 2'd0) q[0] <= {mmatch, mlast, mval};
      else q[1] <= {mmatch, mlast, mval};
    end
  end

  `GMC_ASSERT_IMPL(a_no_overflow, clk, rst, qwr && !qrd, qcnt < 2'd2)
  `GMC_ASSERT_IMPL(a_no_load_busy, clk, rst, state != S_LOAD, !ready)
  `GMC_ASSERT_NEXT(a_trigger_run, clk, rst, trigger, state == S_RUN)
  `GMC_ASSERT_IMPL(a_inflight_bound, clk, rst, 1'b1, 32'(inflight) + 32'(qcnt) <= 2)
endmodule
